[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the reassembly window.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define BRW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("reassembly window assertion failed");

// Clocked assertion that also holds while reset is asserted.
`define BRW_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("reassembly window assertion failed");

`endif

[hdl/brw_pkg.sv]
// ----------------------------------------------------------------------------
// brw_pkg
// Types and codes shared by the block reassembly window modules.
// ----------------------------------------------------------------------------
package brw_pkg;

    // Width of block numbers and of the transfer length.
    localparam int BLOCK_W = 32;
    // Output beat width: status, granted block and complete, padded to bytes.
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W = OUT_TDATA_W - 3 - BLOCK_W - 1;

    // Operation selector carried on the input tuser.
    typedef enum logic [0:0] {
        OP_REQUEST = 1'b0,
        OP_DELIVER = 1'b1
    } t_op;

    // State of one window slot.
    typedef enum logic [1:0] {
        SLOT_EMPTY     = 2'd0,
        SLOT_REQUESTED = 2'd1,
        SLOT_ARRIVED   = 2'd2
    } t_slot;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_DUPLICATE     = 3'd1,
        ST_NO_FREE       = 3'd2,
        ST_NOT_REQUESTED = 3'd3,
        ST_OUTSIDE       = 3'd4
    } t_status;

    // One command handed to the engine.
    typedef struct packed {
        t_op                op;
        logic [BLOCK_W-1:0] block_index;
    } t_cmd;

    // One result handed back by the engine.
    typedef struct packed {
        t_status            status;
        logic [BLOCK_W-1:0] granted_block;
        logic               complete;
    } t_result;

endpackage

[hdl/block_reassembly_window.sv]
// ----------------------------------------------------------------------------
// block_reassembly_window
// Sliding window that grants blocks to fetch and reassembles them in order.
// ----------------------------------------------------------------------------
// Usage: write total_blocks on the cfg channel (always ready), then send one
// beat per operation on the slave stream: tuser selects request or deliver,
// tdata carries the delivered block number. Each input beat yields exactly
// one output beat with status, granted block and the complete flag.
// Timing is set by the sequencer that walks the slot memory one slot per
// cycle: a duplicate or out-of-window delivery ends after the range check,
// a delivery behind the front after one slot read, a delivery at the front
// also scans the run of arrived slots and moves the front, and a request
// scans until it finds an empty slot (at most WINDOW_SLOTS slots). The
// result then passes through the output register. One item is in work at a
// time; tready is low while it runs.
// After reset a clearing pass empties every slot of the slot memory and the
// slave side stays not ready; cfg writes are taken meanwhile.
// A stalled master side holds its beat; the next input beat is still taken,
// and its result waits in the engine until the output register frees up.
// ----------------------------------------------------------------------------
module block_reassembly_window
    import brw_pkg::*;
#(
    parameter int WINDOW_SLOTS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write: total_blocks.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [BLOCK_W-1:0]     i_cfg_data,
    // Slave stream.
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [BLOCK_W-1:0]     i_s_axis_tdata,  // [31:0] block_index
    input  logic [0:0]             i_s_axis_tuser,  // [0] operation
    // Master stream.
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata   // [2:0] status,
                                                    // [34:3] granted_block,
                                                    // [35] complete
);

    logic [BLOCK_W-1:0]     r_total;
    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;
    t_cmd                   cmd;
    t_result                res;
    logic                   res_valid;
    logic                   res_ready;

    // Transfer length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cfg_valid) begin
            r_total <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    assign cmd.op          = t_op'(i_s_axis_tuser);
    assign cmd.block_index = i_s_axis_tdata;

    brw_engine #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (i_s_axis_tvalid),
        .i_cmd          (cmd),
        .o_cmd_ready    (o_s_axis_tready),
        .i_total_blocks (r_total),
        .o_res_valid    (res_valid),
        .o_res          (res),
        .i_res_ready    (res_ready)
    );

    // Output register decouples the engine from the master side.
    assign res_ready = !r_m_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_m_data <= {{OUT_PAD_W{1'b0}}, res.complete, res.granted_block, res.status};
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule

[hdl/brw_slot_ram.sv]
// ----------------------------------------------------------------------------
// brw_slot_ram
// Slot status memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module brw_slot_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 2
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/brw_engine.sv]
// ----------------------------------------------------------------------------
// brw_engine
// Sequencer that runs requests and deliveries over the slot memory, one slot
// per cycle, through a shared subtractor and a shared slot address unit.
// ----------------------------------------------------------------------------
module brw_engine
    import brw_pkg::*;
#(
    parameter int WINDOW_SLOTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_cmd_ready,
    input  logic [BLOCK_W-1:0] i_total_blocks,
    output logic               o_res_valid,
    output t_result            o_res,
    input  logic               i_res_ready
);

    localparam int IW = $clog2(WINDOW_SLOTS);
    localparam int CW = $clog2(WINDOW_SLOTS + 1);
    localparam logic [CW-1:0]      SLOTS_C   = CW'(WINDOW_SLOTS);
    localparam logic [CW:0]        SLOTS_WC  = (CW + 1)'(WINDOW_SLOTS);
    localparam logic [BLOCK_W-1:0] SLOTS_B   = BLOCK_W'(WINDOW_SLOTS);
    localparam logic [IW-1:0]      LAST_ADDR = IW'(WINDOW_SLOTS - 1);

    typedef enum logic [8:0] {
        S_INIT      = 9'b000000001,
        S_IDLE      = 9'b000000010,
        S_SETUP     = 9'b000000100,
        S_REQ_SCAN  = 9'b000001000,
        S_DLV_READ  = 9'b000010000,
        S_DLV_CHECK = 9'b000100000,
        S_RUN_SCAN  = 9'b001000000,
        S_ADVANCE   = 9'b010000000,
        S_FINISH    = 9'b100000000
    } t_state;

    // Physical slot of window offset off, with the window kept circular.
    function automatic logic [IW-1:0] slot_addr(input logic [IW-1:0] base,
                                                input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW + 1)'(base) + (CW + 1)'(off);
        if (sum >= SLOTS_WC) begin
            sum = sum - SLOTS_WC;
        end
        return sum[IW-1:0];
    endfunction

    t_state             r_state, n_state;
    logic [BLOCK_W-1:0] r_front, n_front;
    logic [IW-1:0]      r_base, n_base;
    logic               r_all_arrived, n_all_arrived;
    logic               r_chk_vld, n_chk_vld;
    logic [IW-1:0]      r_clr, n_clr;
    t_op                r_op, n_op;
    logic [BLOCK_W-1:0] r_block, n_block;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_limit, n_limit;
    logic [CW-1:0]      r_chk_idx, n_chk_idx;
    logic [IW-1:0]      r_chk_addr, n_chk_addr;
    logic [IW-1:0]      r_id, n_id;
    logic [CW-1:0]      r_n, n_n;
    t_status            r_status, n_status;
    logic [BLOCK_W-1:0] r_granted, n_granted;

    logic [BLOCK_W-1:0] sub_a;
    logic [BLOCK_W:0]   sub_res;
    logic               sub_borrow;
    logic               front_ge_a;
    logic [CW-1:0]      addr_off;
    logic [IW-1:0]      addr_q;
    logic               issue;
    logic [1:0]         slot_q_raw;
    logic [1:0]         slot_q;
    logic [BLOCK_W:0]   adv_sum;
    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [1:0]         mem_wdata;

    brw_slot_ram #(
        .DEPTH (WINDOW_SLOTS),
        .AW    (IW),
        .DW    (2)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (addr_q),
        .o_rdata (slot_q_raw)
    );

    // Shared subtractor: a minus the front, with the borrow as a compare.
    always_comb begin
        sub_a = i_total_blocks;
        if (r_state == S_SETUP && r_op == OP_DELIVER) begin
            sub_a = r_block;
        end
    end
    assign sub_res    = {1'b0, sub_a} - {1'b0, r_front};
    assign sub_borrow = sub_res[BLOCK_W];
    assign front_ge_a = sub_borrow || (sub_res[BLOCK_W-1:0] == '0);

    // Shared slot address unit.
    always_comb begin
        addr_off = r_idx;
        case (r_state)
            S_DLV_READ: addr_off = CW'(r_id);
            S_ADVANCE:  addr_off = r_n;
            default:    addr_off = r_idx;
        endcase
    end
    assign addr_q = slot_addr(r_base, addr_off);

    // After completion every slot reads arrived.
    assign slot_q  = r_all_arrived ? SLOT_ARRIVED : slot_q_raw;
    assign issue   = (r_idx < r_limit);
    assign adv_sum = {1'b0, r_front} + (BLOCK_W + 1)'(r_n);

    // Sequencer.
    always_comb begin
        n_state       = r_state;
        n_front       = r_front;
        n_base        = r_base;
        n_all_arrived = r_all_arrived;
        n_chk_vld     = r_chk_vld;
        n_clr         = r_clr;
        n_op          = r_op;
        n_block       = r_block;
        n_idx         = r_idx;
        n_limit       = r_limit;
        n_chk_idx     = r_chk_idx;
        n_chk_addr    = r_chk_addr;
        n_id          = r_id;
        n_n           = r_n;
        n_status      = r_status;
        n_granted     = r_granted;
        mem_we        = 1'b0;
        mem_waddr     = r_chk_addr;
        mem_wdata     = SLOT_EMPTY;
        case (r_state)
            // Clearing pass after reset: every slot to empty.
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = SLOT_EMPTY;
                n_clr     = r_clr + 1'b1;
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_op      = i_cmd.op;
                    n_block   = i_cmd.block_index;
                    n_granted = '0;
                    n_state   = S_SETUP;
                end
            end
            // Range checks against the front.
            S_SETUP: begin
                if (r_op == OP_REQUEST) begin
                    if (front_ge_a) begin
                        n_limit = '0;
                    end else if (sub_res[BLOCK_W-1:0] >= SLOTS_B) begin
                        n_limit = SLOTS_C;
                    end else begin
                        n_limit = sub_res[CW-1:0];
                    end
                    n_idx     = '0;
                    n_chk_vld = 1'b0;
                    n_state   = S_REQ_SCAN;
                end else if (sub_borrow) begin
                    n_status = ST_DUPLICATE;
                    n_state  = S_FINISH;
                end else if (sub_res[BLOCK_W-1:0] >= SLOTS_B) begin
                    n_status = ST_OUTSIDE;
                    n_state  = S_FINISH;
                end else begin
                    n_id    = sub_res[IW-1:0];
                    n_state = S_DLV_READ;
                end
            end
            // Search for the lowest empty slot, one read issued per cycle.
            S_REQ_SCAN: begin
                if (r_chk_vld && slot_q == SLOT_EMPTY) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_chk_addr;
                    mem_wdata = SLOT_REQUESTED;
                    n_status  = ST_OK;
                    n_granted = r_front + BLOCK_W'(r_chk_idx);
                    n_state   = S_FINISH;
                end else if (!issue) begin
                    n_status = ST_NO_FREE;
                    n_state  = S_FINISH;
                end else begin
                    n_chk_vld  = 1'b1;
                    n_chk_idx  = r_idx;
                    n_chk_addr = addr_q;
                    n_idx      = r_idx + 1'b1;
                end
            end
            S_DLV_READ: begin
                n_chk_addr = addr_q;
                n_state    = S_DLV_CHECK;
            end
            S_DLV_CHECK: begin
                if (slot_q != SLOT_REQUESTED) begin
                    n_status = ST_NOT_REQUESTED;
                    n_state  = S_FINISH;
                end else if (r_id != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_chk_addr;
                    mem_wdata = SLOT_ARRIVED;
                    n_status  = ST_OK;
                    n_state   = S_FINISH;
                end else begin
                    // Front delivery: the front slot leaves the window.
                    mem_we    = 1'b1;
                    mem_waddr = r_chk_addr;
                    mem_wdata = SLOT_EMPTY;
                    n_n       = CW'(1);
                    n_idx     = CW'(1);
                    n_chk_vld = 1'b0;
                    if (i_total_blocks >= SLOTS_B) begin
                        n_limit = SLOTS_C;
                    end else begin
                        n_limit = i_total_blocks[CW-1:0];
                    end
                    n_state = S_RUN_SCAN;
                end
            end
            // Count the arrived run after the front, emptying each slot of it.
            S_RUN_SCAN: begin
                if (r_chk_vld && slot_q != SLOT_ARRIVED) begin
                    n_state = S_ADVANCE;
                end else begin
                    if (r_chk_vld) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_chk_addr;
                        mem_wdata = SLOT_EMPTY;
                        n_n       = r_chk_idx + 1'b1;
                    end
                    if (!issue) begin
                        n_state = S_ADVANCE;
                    end else begin
                        n_chk_vld  = 1'b1;
                        n_chk_idx  = r_idx;
                        n_chk_addr = addr_q;
                        n_idx      = r_idx + 1'b1;
                    end
                end
            end
            // Move the front past the run, or close the transfer.
            S_ADVANCE: begin
                if (adv_sum >= {1'b0, i_total_blocks}) begin
                    if (!front_ge_a) begin
                        n_front = i_total_blocks;
                    end
                    n_all_arrived = 1'b1;
                end else begin
                    n_front = adv_sum[BLOCK_W-1:0];
                    n_base  = addr_q;
                end
                n_status = ST_OK;
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_clr   = '0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_front       <= '0;
            r_base        <= '0;
            r_all_arrived <= 1'b0;
            r_chk_vld     <= 1'b0;
            r_clr         <= '0;
        end else begin
            r_state       <= n_state;
            r_front       <= n_front;
            r_base        <= n_base;
            r_all_arrived <= n_all_arrived;
            r_chk_vld     <= n_chk_vld;
            r_clr         <= n_clr;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_block    <= n_block;
        r_idx      <= n_idx;
        r_limit    <= n_limit;
        r_chk_idx  <= n_chk_idx;
        r_chk_addr <= n_chk_addr;
        r_id       <= n_id;
        r_n        <= n_n;
        r_status   <= n_status;
        r_granted  <= n_granted;
    end

    assign o_cmd_ready         = (r_state == S_IDLE);
    assign o_res_valid         = (r_state == S_FINISH);
    assign o_res.status        = r_status;
    assign o_res.granted_block = r_granted;
    assign o_res.complete      = front_ge_a;

endmodule

[hdl/brw_checker.sv]
// ----------------------------------------------------------------------------
// brw_checker
// Port level assertions for the block reassembly window, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brw_checker
    import brw_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   i_s_tready,
    input logic                   i_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] i_m_tdata
);

    // Reset starts the clearing pass, so no input beat is taken right after.
    `BRW_ASSERT_NR(a_reset_blocks_input, i_clk, !i_rst_n |=> !i_s_tready)

    // One item at a time: an accepted beat makes the block busy.
    `BRW_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && i_s_tready |=> !i_s_tready)

    // Status codes stay within the defined set.
    `BRW_ASSERT(a_status_range, i_clk, i_rst_n, i_m_tvalid |-> i_m_tdata[2:0] <= ST_OUTSIDE)

    // Only a successful beat may carry a granted block.
    `BRW_ASSERT(a_grant_zero, i_clk, i_rst_n, i_m_tvalid && i_m_tdata[2:0] != ST_OK |-> i_m_tdata[34:3] == '0)

    // A stalled output beat holds.
    `BRW_ASSERT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))

endmodule

bind block_reassembly_window brw_checker u_brw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);
